// File: src/gps_pkg.sv
// Shared types and constants for the GA parent selection core.
`default_nettype none
package gps_pkg;

	localparam int DEF_MAX_POPULATION = 128;
	localparam int IDX_MAX            = 128;
	localparam int CNT_W              = 8;
	localparam int FIT_W              = 16;
	localparam int SUM_W              = 23;
	localparam int SEL_W              = 7;
	localparam int U_W                = 16;
	localparam logic [CNT_W-1:0] POP_RESET = 8'd100;

	typedef enum logic [1:0] {
		OP_WRITE      = 2'd0,
		OP_ROULETTE   = 2'd1,
		OP_TOURNAMENT = 2'd2,
		OP_NOP        = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIN,
		ST_SUM,
		ST_MUL,
		ST_WALK,
		ST_FETCH,
		ST_REPLY,
		ST_TOUR
	} state_t;

	typedef struct packed {
		op_t                    op;
		logic [SEL_W-1:0]       entry_index;
		logic signed [FIT_W-1:0] fitness_value;
		logic [U_W-1:0]         random_fraction;
		logic [SEL_W-1:0]       cand_a;
		logic [SEL_W-1:0]       cand_b;
		logic [SEL_W-1:0]       cand_c;
		logic [SEL_W-1:0]       cand_d;
	} item_t;

	typedef struct packed {
		logic [SEL_W-1:0]        selected_index;
		logic signed [FIT_W-1:0] selected_fitness;
		logic [SUM_W-1:0]        weight_total;
		logic                    status;
	} result_t;

	// shared unit results
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             lt;
		logic             gt;
	} alu_res_t;

endpackage
`default_nettype wire

// File: src/ga_parent_selection_core.sv
// Top level of the GA parent selection core: sequencer, fitness table, result register.
// Write and no-op items: result strobe in the cycle after the transfer, busy stays low.
// Roulette items: busy through three passes over the single table read port (minimum, weight
// sum, walk that stops at the draw), a multiply state before the walk and a fetch after it.
// Tournament items: busy while the four entrants are read and compared. Results strobe in the
// cycle busy drops. Reset: sequencer idle, population_count 100, table undefined until written.
`default_nettype none
module ga_parent_selection_core #(
	parameter int MAX_POPULATION = gps_pkg::DEF_MAX_POPULATION
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire gps_pkg::item_t                item,
	output logic                               done,
	output gps_pkg::result_t                   result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [gps_pkg::CNT_W-1:0]     cfg_data
);
	import gps_pkg::*;

	localparam int IDX_W = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1;
	localparam int NCAP  = (MAX_POPULATION < IDX_MAX) ? MAX_POPULATION : IDX_MAX;
	localparam logic [CNT_W-1:0] NCAP_V = CNT_W'(NCAP);

	// fitness table, one write and one registered read port
	logic signed [FIT_W-1:0] mem [MAX_POPULATION];

	state_t state_q, state_d;
	logic [CNT_W-1:0] pop_q;
	logic [CNT_W-1:0] n_act;
	logic [CNT_W-1:0] n_last;
	logic             accept;

	item_t            item_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       k_q;
	logic             rd_en;
	logic             rd_vld;
	logic [CNT_W-1:0] rd_idx;
	logic [IDX_W-1:0] rd_addr;
	logic             vld_s1;
	logic [CNT_W-1:0] idx_s1;
	logic signed [FIT_W-1:0] rd_data_s1;

	logic signed [FIT_W-1:0] floor_q;
	logic [SUM_W-1:0]        acc_q;
	logic [SUM_W-1:0]        wsum_q;
	logic [SUM_W-1:0]        r_q;
	logic [SEL_W-1:0]        sel_q;
	logic signed [FIT_W-1:0] best_q;
	logic                    have_q;
	logic                    status_q;
	logic [SEL_W-1:0]        cand;
	logic                    last_data;
	logic [U_W+SUM_W:0]      prod;

	logic signed [FIT_W-1:0] alu_ref;
	alu_res_t                alu;

	result_t result_q;
	logic    done_q;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	// active count: saturate to table size capped at IDX_MAX, zero means one
	always_comb begin
		n_act = (pop_q > NCAP_V) ? NCAP_V : pop_q;
		if (n_act == '0) begin
			n_act = CNT_W'(1);
		end
		n_last = n_act - CNT_W'(1);
	end

	assign last_data = vld_s1 && (idx_s1 == n_last);

	// tournament entrant for the current slot
	always_comb begin
		unique case (k_q)
			2'd0:    cand = item_q.cand_a;
			2'd1:    cand = item_q.cand_b;
			2'd2:    cand = item_q.cand_c;
			default: cand = item_q.cand_d;
		endcase
	end

	assign alu_ref = (state_q == ST_TOUR) ? best_q : floor_q;

	gps_alu u_alu (
		.rd_fit  (rd_data_s1),
		.ref_fit (alu_ref),
		.acc     (acc_q),
		.res     (alu)
	);

	// draw r = floor(u * (sum + 1) / 65536); r never exceeds sum
	assign prod = (U_W+SUM_W+1)'(item_q.random_fraction) * (U_W+SUM_W+1)'({1'b0, wsum_q} + 1'b1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (item.op)
						OP_ROULETTE:   state_d = ST_MIN;
						OP_TOURNAMENT: state_d = ST_TOUR;
						default:       state_d = ST_IDLE;
					endcase
				end
			end
			ST_MIN:   if (last_data) state_d = ST_SUM;
			ST_SUM:   if (last_data) state_d = ST_MUL;
			ST_MUL:   state_d = ST_WALK;
			ST_WALK:  if (acc_q >= r_q) state_d = ST_FETCH;
			ST_FETCH: state_d = ST_REPLY;
			ST_REPLY: state_d = ST_IDLE;
			ST_TOUR:  if (k_q == 2'd3 && !rd_en) state_d = ST_REPLY;
			default:  state_d = ST_IDLE;
		endcase
	end

	// read port control
	always_comb begin
		rd_en  = 1'b0;
		rd_vld = 1'b0;
		rd_idx = cnt_q;
		unique case (state_q)
			ST_MIN, ST_SUM, ST_WALK: begin
				rd_en  = (cnt_q < n_act);
				rd_vld = rd_en;
			end
			ST_FETCH: begin
				rd_en  = 1'b1;
				rd_idx = CNT_W'(sel_q);
			end
			ST_TOUR: begin
				// cnt_q counts issued slots; four issues then a drain
				rd_en  = (cnt_q < CNT_W'(4));
				rd_vld = rd_en && ({1'b0, cand} < n_act);
				rd_idx = CNT_W'(cand);
			end
			default: ;
		endcase
		rd_addr = IDX_W'(rd_idx);
	end

	// table write and registered read
	always_ff @(posedge clk) begin
		if (accept && item.op == OP_WRITE && int'(item.entry_index) < MAX_POPULATION) begin
			mem[IDX_W'(item.entry_index)] <= item.fitness_value;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pop_q   <= POP_RESET;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_vld;
			done_q  <= (accept && item.op != OP_ROULETTE && item.op != OP_TOURNAMENT)
				|| (state_q == ST_REPLY);
			if (cfg_valid && cfg_ready) begin
				pop_q <= cfg_data;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx;
		if (rd_en) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (state_q == ST_TOUR && rd_en) begin
			k_q <= (k_q == 2'd3) ? k_q : k_q + 2'd1;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_q   <= item;
					cnt_q    <= '0;
					k_q      <= '0;
					acc_q    <= '0;
					sel_q    <= '0;
					have_q   <= 1'b0;
					status_q <= ({1'b0, item.cand_a} >= n_act) || ({1'b0, item.cand_b} >= n_act)
						|| ({1'b0, item.cand_c} >= n_act) || ({1'b0, item.cand_d} >= n_act);
					// write and no-op results are all zero apart from the write range flag
					result_q <= '{selected_index: '0, selected_fitness: '0, weight_total: '0,
						status: (item.op == OP_WRITE) && ({1'b0, item.entry_index} >= n_act)};
				end
			end
			ST_MIN: begin
				if (vld_s1 && (idx_s1 == '0 || alu.lt)) begin
					floor_q <= rd_data_s1;
				end
				if (last_data) begin
					cnt_q <= '0;
				end
			end
			ST_SUM: begin
				if (vld_s1) begin
					acc_q <= alu.sum;
				end
				if (last_data) begin
					wsum_q <= alu.sum;
				end
			end
			ST_MUL: begin
				r_q   <= prod[U_W+SUM_W-1:U_W];
				acc_q <= '0;
				cnt_q <= '0;
			end
			ST_WALK: begin
				if (vld_s1 && acc_q < r_q) begin
					acc_q <= alu.sum;
					sel_q <= idx_s1[SEL_W-1:0];
				end
			end
			ST_FETCH: ;
			ST_TOUR: begin
				if (vld_s1 && (!have_q || alu.gt)) begin
					have_q <= 1'b1;
					best_q <= rd_data_s1;
					sel_q  <= idx_s1[SEL_W-1:0];
				end
			end
			ST_REPLY: begin
				if (item_q.op == OP_ROULETTE) begin
					result_q.selected_index   <= sel_q;
					result_q.selected_fitness <= rd_data_s1;
					result_q.weight_total     <= wsum_q;
					result_q.status           <= 1'b0;
				end else begin
					result_q.selected_index   <= have_q ? sel_q : '0;
					result_q.selected_fitness <= have_q ? best_q : '0;
					result_q.weight_total     <= '0;
					result_q.status           <= status_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: src/gps_alu.sv
// Shared subtract/accumulate/compare unit used by every table pass.
`default_nettype none
module gps_alu (
	input  wire logic signed [gps_pkg::FIT_W-1:0] rd_fit,
	input  wire logic signed [gps_pkg::FIT_W-1:0] ref_fit,
	input  wire logic [gps_pkg::SUM_W-1:0]        acc,
	output gps_pkg::alu_res_t                     res
);
	import gps_pkg::*;

	logic signed [FIT_W:0] diff;

	// weight = rd - ref; nonnegative whenever ref is the table minimum
	always_comb begin
		diff    = {rd_fit[FIT_W-1], rd_fit} - {ref_fit[FIT_W-1], ref_fit};
		res.sum = acc + SUM_W'(diff[FIT_W-1:0]);
		res.lt  = diff[FIT_W];
		res.gt  = !diff[FIT_W] && (diff != '0);
	end

endmodule
`default_nettype wire
